// File: sv/ftfat_pkg.sv
// Shared constants, types and the month-start table for the FAT timestamp pipeline.
// Used by every module of the block; depends on nothing.
package ftfat_pkg;

	localparam int FtW   = 64;
	localparam int OffW  = 18;
	localparam int SecW  = 41;
	localparam int DayW  = 25;
	localparam int TodW  = 17;
	localparam int FatW  = 32;

	// Ticks to seconds: ticks >> 7, then divide by 78125.
	localparam logic [16:0] SecDiv   = 17'd78125;
	localparam logic [40:0] SecRecip = 41'd1844674407370;

	// Seconds to days: seconds >> 7, then divide by 675.
	localparam logic [16:0] SecsPerDay = 17'd86400;
	localparam logic [24:0] DayRecip   = 25'd25451658;

	// Day numbers.
	localparam logic [24:0] DaysTo1980   = 25'd138426;
	localparam logic [24:0] CivilBase    = 25'd723120;
	localparam logic [24:0] CivilShift   = 25'd584694;
	localparam logic [17:0] DaysPerEra   = 18'd146097;
	localparam logic [7:0]  EraRecip     = 8'd229;
	localparam logic [15:0] YearRecip    = 16'd45965;
	localparam logic [8:0]  DaysPerYear  = 9'd365;
	localparam logic [17:0] Cent1        = 18'd36524;
	localparam logic [17:0] Cent2        = 18'd73048;
	localparam logic [17:0] Cent3        = 18'd109572;
	localparam logic [17:0] EraLastDay   = 18'd146096;
	localparam logic [12:0] MonRecip     = 13'd6854;
	localparam logic [15:0] EpochYear    = 16'd1980;
	localparam logic [15:0] LastYear     = 16'd2107;
	localparam logic [8:0]  YearsPerEra  = 9'd400;

	// Time of day.
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [12:0] HourRecip   = 13'd4661;
	localparam logic [12:0] MinRecip    = 13'd4370;
	localparam logic [5:0]  SecsPerMin  = 6'd60;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [4:0] sec2;
	} tm_t;

	// First day of year of each month, counting months from March.
	function automatic logic [8:0] mp_day(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: sv/ftfat_sec_div.sv
// Six-stage pipeline: tick count to whole seconds, then the signed zone offset.
// Depends on ftfat_pkg.
module ftfat_sec_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [ftfat_pkg::FtW-1:0]      filetime,
	input  logic [ftfat_pkg::OffW-1:0]     gmt_offset,
	output logic                           out_valid,
	output logic [ftfat_pkg::SecW-1:0]     secs
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [63:0] pp_ll_s1;
	logic [40:0] pp_lh_s1;
	logic [56:0] pp_hl_s1;
	logic [33:0] pp_hh_s1;
	logic [17:0] xlo_s1, xlo_s2, xlo_s3;
	logic [58:0] t_s2;
	logic [33:0] hh_s2;
	logic [40:0] q0_s3, q0_s4;
	logic [17:0] r_s4;
	logic [40:0] secs_s5, local_s6;

	logic [65:0] a_sum;
	logic [34:0] r_prod;
	logic [17:0] mag;
	logic [40:0] local_d;

	always_comb begin
		a_sum = {hh_s2, 32'd0} + 66'(t_s2);
		r_prod = 35'(q0_s3[17:0]) * 35'(ftfat_pkg::SecDiv);
		mag = ~gmt_offset + 18'd1;
		if (gmt_offset[17]) begin
			local_d = (secs_s5 < 41'(mag)) ? 41'd0 : secs_s5 - 41'(mag);
		end else begin
			local_d = secs_s5 + 41'(gmt_offset[16:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= 64'(filetime[38:7]) * 64'(ftfat_pkg::SecRecip[31:0]);
			pp_lh_s1 <= 41'(filetime[38:7]) * 41'(ftfat_pkg::SecRecip[40:32]);
			pp_hl_s1 <= 57'(filetime[63:39]) * 57'(ftfat_pkg::SecRecip[31:0]);
			pp_hh_s1 <= 34'(filetime[63:39]) * 34'(ftfat_pkg::SecRecip[40:32]);
			xlo_s1   <= filetime[24:7];

			t_s2   <= 59'(pp_lh_s1) + 59'(pp_hl_s1) + 59'(pp_ll_s1[63:32]);
			hh_s2  <= pp_hh_s1;
			xlo_s2 <= xlo_s1;

			q0_s3  <= a_sum[65:25];
			xlo_s3 <= xlo_s2;

			q0_s4 <= q0_s3;
			r_s4  <= xlo_s3 - r_prod[17:0];

			secs_s5 <= q0_s4 + 41'(r_s4 >= 18'(ftfat_pkg::SecDiv));

			local_s6 <= local_d;
		end
	end

	assign out_valid = v_s6;
	assign secs      = local_s6;

	// The quotient estimate is at most one short, so the remainder stays below twice the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (r_s4 < {ftfat_pkg::SecDiv, 1'b0}))
		else $error("seconds remainder out of range");

endmodule

// File: sv/ftfat_day_div.sv
// Four-stage pipeline: local seconds to a day number and a second of the day.
// Depends on ftfat_pkg.
module ftfat_day_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [ftfat_pkg::SecW-1:0]     secs,
	output logic                           out_valid,
	output logic [ftfat_pkg::DayW-1:0]     days,
	output logic [ftfat_pkg::TodW-1:0]     tod
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [56:0] ppl_s1;
	logic [26:0] pph_s1;
	logic [17:0] lo_s1, lo_s2;
	logic [24:0] q0_s2, q0_s3;
	logic [17:0] th_s3;
	logic [24:0] days_s4;
	logic [16:0] tod_s4;

	logic [58:0] q_sum;
	logic [34:0] t_prod;
	logic        wrap;
	logic [17:0] th_sub;

	always_comb begin
		q_sum  = {pph_s1, 32'd0} + 59'(ppl_s1);
		t_prod = 35'(q0_s2[17:0]) * 35'(ftfat_pkg::SecsPerDay);
		wrap   = th_s3 >= 18'(ftfat_pkg::SecsPerDay);
		th_sub = th_s3 - 18'(ftfat_pkg::SecsPerDay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ppl_s1 <= 57'(secs[38:7]) * 57'(ftfat_pkg::DayRecip);
			pph_s1 <= 27'(secs[40:39]) * 27'(ftfat_pkg::DayRecip);
			lo_s1  <= secs[17:0];

			q0_s2 <= q_sum[58:34];
			lo_s2 <= lo_s1;

			q0_s3 <= q0_s2;
			th_s3 <= lo_s2 - t_prod[17:0];

			days_s4 <= q0_s3 + 25'(wrap);
			tod_s4  <= wrap ? th_sub[16:0] : th_s3[16:0];
		end
	end

	assign out_valid = v_s4;
	assign days      = days_s4;
	assign tod       = tod_s4;

	a_tod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (th_s3 < {ftfat_pkg::SecsPerDay, 1'b0}))
		else $error("second of day estimate out of range");

	a_tod_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (tod_s4 < ftfat_pkg::SecsPerDay))
		else $error("second of day not reduced");

endmodule

// File: sv/ftfat_civil.sv
// Nine-stage pipeline: day number and second of day to the packed FAT word.
// Date and time of day are split in parallel; depends on ftfat_pkg.
module ftfat_civil (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [ftfat_pkg::DayW-1:0]     days,
	input  logic [ftfat_pkg::TodW-1:0]     tod,
	output logic                           out_valid,
	output logic [ftfat_pkg::FatW-1:0]     fat_time,
	output logic                           year_overflow
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [24:0] z_s1, z_s2;
	logic [16:0] tod_s1;
	logic [4:0]  hour_s1, hour_s2, hour_s3;
	logic [7:0]  era0_s2, era0_s3;
	logic [11:0] rem_s2, rem_s3;
	logic [18:0] doeh_s3;
	logic [5:0]  minute_s3;
	logic [7:0]  era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [17:0] doe_s4, doe_s5, doe_s6;
	ftfat_pkg::tm_t tm_s4, tm_s5, tm_s6, tm_s7, tm_s8;
	logic [17:0] a_s5;
	logic [8:0]  yoe_s6, yoe_s7, yoe_s8;
	logic [8:0]  doy_s7, doy_s8;
	logic [3:0]  mp_s8;
	logic [31:0] fat_s9;
	logic        over_s9;

	logic [24:0] z_d;
	logic [25:0] h_prod;
	logic [16:0] rem_full;
	logic [32:0] e_prod;
	logic [24:0] d_prod, doe_diff;
	logic [22:0] m_prod;
	logic        era_wrap;
	logic [18:0] doe_sub;
	logic [11:0] sec_full;
	logic [31:0] q_prod;
	logic [2:0]  cent;
	logic [18:0] a_d;
	logic [33:0] y_prod;
	logic [1:0]  c100;
	logic [17:0] ystart, doy_full;
	logic [10:0] mp_n;
	logic [23:0] mp_prod;
	logic [8:0]  day_full;
	logic [3:0]  month;
	logic [15:0] year, yoff;

	always_comb begin
		z_d = (days < ftfat_pkg::DaysTo1980) ? ftfat_pkg::CivilBase
			: days + ftfat_pkg::CivilShift;
		h_prod = 26'(tod[16:4]) * 26'(ftfat_pkg::HourRecip);

		e_prod   = 33'(z_s1) * 33'(ftfat_pkg::EraRecip);
		rem_full = tod_s1 - 17'(17'(hour_s1) * 17'(ftfat_pkg::SecsPerHour));

		d_prod   = 25'(era0_s2) * 25'(ftfat_pkg::DaysPerEra);
		doe_diff = z_s2 - d_prod;
		m_prod   = 23'(rem_s2[11:2]) * 23'(ftfat_pkg::MinRecip);

		era_wrap = doeh_s3 >= 19'(ftfat_pkg::DaysPerEra);
		doe_sub  = doeh_s3 - 19'(ftfat_pkg::DaysPerEra);
		sec_full = rem_s3 - 12'(12'(minute_s3) * 12'(ftfat_pkg::SecsPerMin));

		q_prod = 32'(doe_s4[17:2]) * 32'(ftfat_pkg::YearRecip);
		cent   = 3'(doe_s4 >= ftfat_pkg::Cent1) + 3'(doe_s4 >= ftfat_pkg::Cent2)
			+ 3'(doe_s4 >= ftfat_pkg::Cent3) + 3'(doe_s4 >= ftfat_pkg::EraLastDay);
		a_d    = 19'(doe_s4) - 19'(q_prod[30:24]) + 19'(cent)
			- 19'(doe_s4 == ftfat_pkg::EraLastDay);

		y_prod = 34'(a_s5) * 34'(ftfat_pkg::YearRecip);

		c100 = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
		ystart = 18'(18'(yoe_s6) * 18'(ftfat_pkg::DaysPerYear)) + 18'(yoe_s6[8:2])
			- 18'(c100);
		doy_full = doe_s6 - ystart;

		mp_n    = 11'(11'(doy_s7) * 11'd5) + 11'd2;
		mp_prod = 24'(mp_n) * 24'(ftfat_pkg::MonRecip);

		day_full = doy_s8 - ftfat_pkg::mp_day(mp_s8) + 9'd1;
		month    = (mp_s8 >= 4'd10) ? mp_s8 - 4'd9 : mp_s8 + 4'd3;
		year     = 16'(16'(era_s8) * 16'(ftfat_pkg::YearsPerEra)) + 16'(yoe_s8)
			+ 16'(mp_s8 >= 4'd10);
		yoff     = year - ftfat_pkg::EpochYear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= z_d;
			tod_s1  <= tod;
			hour_s1 <= h_prod[24:20];

			z_s2    <= z_s1;
			era0_s2 <= e_prod[32:25];
			rem_s2  <= rem_full[11:0];
			hour_s2 <= hour_s1;

			doeh_s3   <= doe_diff[18:0];
			era0_s3   <= era0_s2;
			minute_s3 <= m_prod[21:16];
			rem_s3    <= rem_s2;
			hour_s3   <= hour_s2;

			era_s4 <= era0_s3 + 8'(era_wrap);
			doe_s4 <= era_wrap ? doe_sub[17:0] : doeh_s3[17:0];
			tm_s4  <= '{hour: hour_s3, minute: minute_s3, sec2: sec_full[5:1]};

			a_s5   <= a_d[17:0];
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
			tm_s5  <= tm_s4;

			yoe_s6 <= y_prod[32:24];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
			tm_s6  <= tm_s5;

			doy_s7 <= doy_full[8:0];
			yoe_s7 <= yoe_s6;
			era_s7 <= era_s6;
			tm_s7  <= tm_s6;

			mp_s8  <= mp_prod[23:20];
			doy_s8 <= doy_s7;
			yoe_s8 <= yoe_s7;
			era_s8 <= era_s7;
			tm_s8  <= tm_s7;

			fat_s9  <= {yoff[6:0], month, day_full[4:0], tm_s8.hour, tm_s8.minute,
				tm_s8.sec2};
			over_s9 <= year > ftfat_pkg::LastYear;
		end
	end

	assign out_valid     = v_s9;
	assign fat_time      = fat_s9;
	assign year_overflow = over_s9;

	a_doe_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (doe_s4 <= ftfat_pkg::EraLastDay))
		else $error("day of era out of range");

	a_date_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (fat_s9[24:21] != 4'd0 && fat_s9[24:21] <= 4'd12
			&& fat_s9[20:16] != 5'd0))
		else $error("month or day field out of range");

	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (fat_s9[15:11] <= 5'd23 && fat_s9[10:5] <= 6'd59
			&& fat_s9[4:0] <= 5'd29))
		else $error("time of day field out of range");

endmodule

// File: sv/filetime_to_fat_timestamp.sv
// Top level of the tick count to FAT date/time converter: offset register and pipeline control.
// Depends on ftfat_pkg, ftfat_sec_div, ftfat_day_div and ftfat_civil.
//
//   Channel  Signals                          Carries
//   config   cfg_wr_en, cfg_wr_data           gmt_offset, signed seconds
//   input    in_valid, in_ready, filetime     100 ns ticks since 1601-01-01
//   output   out_valid, out_ready, fat_time,  packed FAT word and year wrap flag
//            year_overflow
//
// One transfer can be taken in every cycle in which in_ready is high.
// The 19 stages are the seconds divider (6), the day divider (4) and the calendar split (9).
// When the output holds a result that is not taken, every stage holds; nothing is lost.
// Reset clears all valid bits and sets the offset to zero.
module filetime_to_fat_timestamp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic signed [ftfat_pkg::OffW-1:0] cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ftfat_pkg::FtW-1:0]         filetime,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ftfat_pkg::FatW-1:0]        fat_time,
	output logic                              year_overflow
);

	logic signed [ftfat_pkg::OffW-1:0] gmt_offset_q;
	logic                              en;
	logic                              sec_valid;
	logic [ftfat_pkg::SecW-1:0]        secs;
	logic                              day_valid;
	logic [ftfat_pkg::DayW-1:0]        days;
	logic [ftfat_pkg::TodW-1:0]        tod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmt_offset_q <= '0;
		end else if (cfg_wr_en) begin
			gmt_offset_q <= cfg_wr_data;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	ftfat_sec_div u_sec_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.filetime   (filetime),
		.gmt_offset (gmt_offset_q),
		.out_valid  (sec_valid),
		.secs       (secs)
	);

	ftfat_day_div u_day_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sec_valid),
		.secs      (secs),
		.out_valid (day_valid),
		.days      (days),
		.tod       (tod)
	);

	ftfat_civil u_civil (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (day_valid),
		.days          (days),
		.tod           (tod),
		.out_valid     (out_valid),
		.fat_time      (fat_time),
		.year_overflow (year_overflow)
	);

endmodule

// File: tb/sv/tb.sv
// Testbench for filetime_to_fat_timestamp: directed table plus random tick counts over offsets.
// Results are checked in order against typed table values or a local calendar model; needs only ftfat_pkg and the RTL.
module tb;

	localparam longint unsigned TicksPerSec = 64'd10000000;
	localparam longint unsigned DaySecs     = 64'd86400;
	localparam longint unsigned EpochDays   = 64'd138426;
	localparam longint unsigned UnixToEpoch = 64'd3652;
	localparam longint unsigned MarchShift  = 64'd719468;
	localparam longint unsigned OffsetSpan  = 64'd262144;
	localparam longint unsigned Secs1980    = 64'd11960006400;
	localparam longint unsigned Secs2100Mar = 64'd15752016000;
	localparam int CycleLimit   = 1000000;
	localparam int PhaseItems   = 305;
	localparam int HoldCycles   = 300;
	localparam int DrainCycles  = 40;

	typedef struct packed {
		logic [ftfat_pkg::FatW-1:0] fat;
		logic                       wrap;
	} fat_result_t;

	typedef struct packed {
		logic signed [ftfat_pkg::OffW-1:0] offset;
		logic [ftfat_pkg::FtW-1:0]         ticks;
		logic                              typed;
		logic [ftfat_pkg::FatW-1:0]        fat;
		logic                              wrap;
	} stim_row_t;

	localparam int NumRows = 22;

	stim_row_t dir_rows [NumRows] = '{
		'{18'sd0,       64'd0,                  1'b1, 32'h0021_0000, 1'b0},
		'{18'sd0,       64'd119600064000000000, 1'b1, 32'h0021_0000, 1'b0},
		'{18'sd0,       64'd119600063990000000, 1'b1, 32'h0021_BF7D, 1'b0},
		'{18'sd0,       64'd119600064009999999, 1'b1, 32'h0021_0000, 1'b0},
		'{18'sd0,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'd159992927990000000, 1'b1, 32'hFF9F_BF7D, 1'b0},
		'{18'sd0,       64'd159992928000000000, 1'b1, 32'h0021_0000, 1'b1},
		'{18'sd0,       64'd157520160000000000, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'd157519296000000000, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'd125962560000000000, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'h5555_5555_5555_5555, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'h0,        1'b0},
		'{18'sd131071,  64'd0,                  1'b1, 32'h0021_630F, 1'b0},
		'{18'sd131071,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0,        1'b0},
		'{18'sd131071,  64'd159992927990000000, 1'b0, 32'h0,        1'b0},
		'{-18'sd131072, 64'd0,                  1'b1, 32'h0021_0000, 1'b0},
		'{-18'sd131072, 64'd119600064000000000, 1'b1, 32'h0021_5C6E, 1'b0},
		'{-18'sd131072, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0,        1'b0},
		'{-18'sd1,      64'd0,                  1'b1, 32'h0021_0000, 1'b0},
		'{18'sd86400,   64'd119600063990000000, 1'b0, 32'h0,        1'b0},
		'{-18'sd86400,  64'd157520160000000000, 1'b0, 32'h0,        1'b0},
		'{18'sd0,       64'd1,                  1'b0, 32'h0,        1'b0}
	};

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic signed [ftfat_pkg::OffW-1:0] cfg_wr_data;
	logic                              in_valid;
	logic                              in_ready;
	logic [ftfat_pkg::FtW-1:0]         filetime;
	logic                              out_valid;
	logic                              out_ready;
	logic [ftfat_pkg::FatW-1:0]        fat_time;
	logic                              year_overflow;

	fat_result_t                       fat_expected_q[$];
	logic signed [ftfat_pkg::OffW-1:0] cur_offset;
	int                                mismatches;
	int                                cycle_count;
	bit                                hold_request;
	bit                                sender_no_gaps;

	filetime_to_fat_timestamp u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.filetime      (filetime),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fat_time      (fat_time),
		.year_overflow (year_overflow)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic fat_result_t fat_of_filetime(input logic [ftfat_pkg::FtW-1:0] ticks,
			input logic signed [ftfat_pkg::OffW-1:0] offset);
		longint unsigned secs, mag, days, tod, d80, z, era, doe, yoe, doy, mp, mon, mday, yr;
		fat_result_t     res;
		secs = ticks / TicksPerSec;
		if (offset < 0) begin
			mag  = OffsetSpan - {46'd0, offset};
			secs = (secs < mag) ? 64'd0 : secs - mag;
		end else begin
			secs = secs + {46'd0, offset};
		end
		days = secs / DaySecs;
		tod  = secs % DaySecs;
		d80  = (days < EpochDays) ? 64'd0 : days - EpochDays;
		z    = d80 + UnixToEpoch + MarchShift;
		era  = z / 64'd146097;
		doe  = z - era * 64'd146097;
		yoe  = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
		doy  = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
		mp   = (64'd5 * doy + 64'd2) / 64'd153;
		mon  = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
		mday = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
		yr   = yoe + era * 64'd400 + ((mon <= 64'd2) ? 64'd1 : 64'd0);
		res.fat = {7'(yr - 64'd1980), 4'(mon), 5'(mday), 5'(tod / 64'd3600),
			6'((tod % 64'd3600) / 64'd60), 5'((tod % 64'd60) >> 1)};
		res.wrap = (yr > 64'd2107);
		return res;
	endfunction

	function automatic logic [ftfat_pkg::FtW-1:0] draw_filetime();
		logic [ftfat_pkg::FtW-1:0] secs;
		logic [ftfat_pkg::FtW-1:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				secs = Secs1980 - 64'd200000 + raw % 64'd5184000000;
				return secs * TicksPerSec + 64'($urandom_range(0, 9999999));
			end
			4, 5: begin
				secs = (EpochDays + 64'($urandom_range(0, 50000))) * DaySecs - 64'd2
					+ 64'($urandom_range(0, 4));
				return secs * TicksPerSec + 64'($urandom_range(0, 9999999));
			end
			6, 7: begin
				return raw;
			end
			8: begin
				return raw >> $urandom_range(0, 63);
			end
			default: begin
				secs = Secs2100Mar - 64'd400 * DaySecs + raw % 64'd283824000;
				return secs * TicksPerSec + 64'($urandom_range(0, 9999999));
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [ftfat_pkg::FtW-1:0] ticks, input logic typed,
			input fat_result_t typed_res);
		int gap;
		gap = sender_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		filetime = ticks;
		do @(posedge clk); while (!in_ready);
		fat_expected_q.push_back(typed ? typed_res : fat_of_filetime(ticks, cur_offset));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (fat_expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_offset(input logic signed [ftfat_pkg::OffW-1:0] value);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en  = 1'b0;
		cur_offset = value;
	endtask

	initial begin
		fat_result_t                       typed_res;
		logic signed [ftfat_pkg::OffW-1:0] phase_offset;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		filetime       = '0;
		cur_offset     = '0;
		mismatches     = 0;
		hold_request   = 1'b0;
		sender_no_gaps = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NumRows; i++) begin
			if (dir_rows[i].offset != cur_offset) begin
				write_offset(dir_rows[i].offset);
			end
			typed_res.fat  = dir_rows[i].fat;
			typed_res.wrap = dir_rows[i].wrap;
			send_item(dir_rows[i].ticks, dir_rows[i].typed, typed_res);
		end

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       phase_offset = 18'sd131071;
				1:       phase_offset = -18'sd131072;
				2:       phase_offset = 18'sd86400;
				3:       phase_offset = -18'sd86400;
				default: phase_offset = 18'($urandom);
			endcase
			write_offset(phase_offset);
			sender_no_gaps = (phase == 0 || phase == 3);
			for (int n = 0; n < PhaseItems; n++) begin
				if (phase == 1 && n == 100) begin
					hold_request = 1'b1;
				end
				if (phase == 4 && n == PhaseItems / 2) begin
					drain();
				end
				send_item(draw_filetime(), 1'b0, typed_res);
			end
		end

		drain();
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		int run;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_request = 1'b0;
			end
			out_ready = 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
			repeat (run) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		fat_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (fat_expected_q.size() == 0) begin
				$error("result with no expectation: fat_time %h year_overflow %b",
					fat_time, year_overflow);
				mismatches++;
			end else begin
				want = fat_expected_q.pop_front();
				if (fat_time !== want.fat) begin
					$error("fat_time expected %h actual %h", want.fat, fat_time);
					mismatches++;
				end
				if (year_overflow !== want.wrap) begin
					$error("year_overflow expected %b actual %b", want.wrap, year_overflow);
					mismatches++;
				end
			end
		end
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
